>>> sv/matrix_multiply_unit_defines.svh
// Assertion macros used by the matrix multiply unit back end RTL.
`ifndef MATRIX_MULTIPLY_UNIT_DEFINES_SVH
`define MATRIX_MULTIPLY_UNIT_DEFINES_SVH
`ifndef ASSERT_OFF
// Same-cycle implication, checked outside reset.
`define MMU_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("matrix multiply unit assertion failed");
// Next-cycle implication, checked outside reset.
`define MMU_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("matrix multiply unit assertion failed");
`else
`define MMU_ASSERT_IMPLY(label, clk, rst_n, ante, cons)
`define MMU_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

>>> sv/mmu_pkg.sv
// Package: types, codes and constants of the matrix multiply unit.
package mmu_pkg;

    localparam int MAX_DIM_DEF    = 8;
    localparam int DATA_WIDTH_DEF = 16;

    localparam int CFG_W      = 4;
    localparam int VALUE_W    = 16;
    localparam int ROWCOL_W   = 3;
    localparam int PRODUCT_W  = 35;
    localparam int OP_W       = 2;
    localparam int CMD_DEPTH  = 4;
    localparam int RES_DEPTH  = 4;

    localparam logic [CFG_W-1:0] CFG_RESET = 4'd8;

    typedef logic [1:0] t_reg_idx;
    localparam t_reg_idx REG_ROWS_A    = 2'd0;
    localparam t_reg_idx REG_INNER_DIM = 2'd1;
    localparam t_reg_idx REG_COLS_B    = 2'd2;

    typedef logic [OP_W-1:0] t_op;
    localparam t_op OP_WRITE_A = 2'd0;
    localparam t_op OP_WRITE_B = 2'd1;
    localparam t_op OP_COMPUTE = 2'd2;

    // Head of the command queue as seen by the back end.
    typedef struct packed {
        logic avail;
        t_op  op;
    } t_cmd_status;

    // Bookkeeping that travels alongside one MAC step.
    typedef struct packed {
        logic                first;
        logic                last;
        logic                zero;
        logic                fin;
        logic [ROWCOL_W-1:0] row;
        logic [ROWCOL_W-1:0] col;
    } t_step_tag;

endpackage

>>> sv/matrix_multiply_unit.sv
// Matrix multiply unit: C = A * B over signed Q8.8 elements, signed Q19.16 results.
// Element writes: one transfer per cycle while no compute runs, stored through the command queue;
// behind a compute they wait in the 4-deep command queue, with full high once it fills.
// Compute: one MAC per cycle, max(inner_dim,1) MAC steps per C entry, rows_a * cols_b entries,
// each dimension clamped to MAX_DIM; an entry waits for a free result slot, so a full result queue stalls it.
// Sync active-low reset: queues emptied, dimensions set to 8, operand stores left uncleared.
module matrix_multiply_unit #(
    parameter int MAX_DIM    = mmu_pkg::MAX_DIM_DEF,
    parameter int DATA_WIDTH = mmu_pkg::DATA_WIDTH_DEF
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    // item side
    input  logic                                  push,
    output logic                                  full,
    input  mmu_pkg::t_op                          i_op,
    input  logic [mmu_pkg::ROWCOL_W-1:0]          i_row,
    input  logic [mmu_pkg::ROWCOL_W-1:0]          i_col,
    input  logic signed [mmu_pkg::VALUE_W-1:0]    i_value,
    // result side
    output logic                                  empty,
    input  logic                                  pop,
    output logic signed [mmu_pkg::PRODUCT_W-1:0]  o_product,
    output logic [mmu_pkg::ROWCOL_W-1:0]          o_out_row,
    output logic [mmu_pkg::ROWCOL_W-1:0]          o_out_col,
    output logic                                  o_last,
    // configuration write channel
    input  logic                                  i_cfg_valid,
    output logic                                  o_cfg_ready,
    input  mmu_pkg::t_reg_idx                     i_cfg_index,
    input  logic [mmu_pkg::CFG_W-1:0]             i_cfg_data
);

    localparam int ADDR_W = $clog2(MAX_DIM * MAX_DIM);

    logic [mmu_pkg::CFG_W-1:0] r_rows_a, r_inner_dim, r_cols_b;
    mmu_pkg::t_cmd_status      cmd;
    logic [ADDR_W-1:0]         cmd_addr;
    logic [DATA_WIDTH-1:0]     cmd_value;
    logic                      cmd_pop;

    // Dimension registers. The user must write them only while the unit is idle;
    // the block does not enforce this, and the channel never pushes back.
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rows_a    <= mmu_pkg::CFG_RESET;
            r_inner_dim <= mmu_pkg::CFG_RESET;
            r_cols_b    <= mmu_pkg::CFG_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                mmu_pkg::REG_ROWS_A:    r_rows_a    <= i_cfg_data;
                mmu_pkg::REG_INNER_DIM: r_inner_dim <= i_cfg_data;
                mmu_pkg::REG_COLS_B:    r_cols_b    <= i_cfg_data;
                default:                ; // unmapped index, write dropped
            endcase
        end
    end

    // Front end: every transfer with full low is taken; unused opcodes and
    // out-of-range writes are dropped here, the rest enter the command queue.
    mmu_front #(
        .MAX_DIM    (MAX_DIM),
        .DATA_WIDTH (DATA_WIDTH)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .i_op        (i_op),
        .i_row       (i_row),
        .i_col       (i_col),
        .i_value     (i_value),
        .o_full      (full),
        .o_cmd       (cmd),
        .o_cmd_addr  (cmd_addr),
        .o_cmd_value (cmd_value),
        .i_cmd_pop   (cmd_pop)
    );

    // Back end: writes land in the stores in queue order, so a compute only
    // sees writes accepted before it. A compute walks C row-major; each entry
    // reserves a result slot before it starts, so the MAC pipeline never stalls
    // and the result queue never overflows.
    mmu_back #(
        .MAX_DIM    (MAX_DIM),
        .DATA_WIDTH (DATA_WIDTH)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .i_cmd_addr  (cmd_addr),
        .i_cmd_value (cmd_value),
        .o_cmd_pop   (cmd_pop),
        .i_rows_a    (r_rows_a),
        .i_inner_dim (r_inner_dim),
        .i_cols_b    (r_cols_b),
        .i_res_pop   (pop),
        .o_res_empty (empty),
        .o_product   (o_product),
        .o_out_row   (o_out_row),
        .o_out_col   (o_out_col),
        .o_last      (o_last)
    );

endmodule

>>> sv/mmu_ram.sv
// Generic single-write, single-read RAM with registered read data.
module mmu_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

>>> sv/mmu_fifo.sv
// Small synchronous FIFO with full, empty and fill count.
module mmu_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4,
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1,
    localparam int CNT_W = $clog2(DEPTH + 1)
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_data,
    output logic             o_full,
    output logic             o_empty,
    output logic [CNT_W-1:0] o_count
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PTR_W-1:0] r_wptr, r_rptr;
    logic [CNT_W-1:0] r_count, n_count;
    logic             push_ok, pop_ok;

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        logic [PTR_W-1:0] res;
        if (p == PTR_W'(DEPTH - 1)) res = '0;
        else res = p + 1'b1;
        return res;
    endfunction

    assign o_full  = (r_count == CNT_W'(DEPTH));
    assign o_empty = (r_count == '0);
    assign o_count = r_count;
    assign o_data  = r_mem[r_rptr];
    assign push_ok = i_push && !o_full;
    assign pop_ok  = i_pop && !o_empty;

    always_comb begin
        case ({push_ok, pop_ok})
            2'b10:   n_count = r_count + 1'b1;
            2'b01:   n_count = r_count - 1'b1;
            default: n_count = r_count;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (push_ok) r_wptr <= ptr_inc(r_wptr);
            if (pop_ok)  r_rptr <= ptr_inc(r_rptr);
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push_ok) begin
            r_mem[r_wptr] <= i_data;
        end
    end

endmodule

>>> sv/mmu_front.sv
// Front end: accepts items, drops ignored ones, queues commands for the back end.
module mmu_front #(
    parameter int MAX_DIM    = mmu_pkg::MAX_DIM_DEF,
    parameter int DATA_WIDTH = mmu_pkg::DATA_WIDTH_DEF,
    localparam int ADDR_W = $clog2(MAX_DIM * MAX_DIM),
    localparam int CMD_W  = mmu_pkg::OP_W + ADDR_W + DATA_WIDTH
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_push,
    input  mmu_pkg::t_op                        i_op,
    input  logic [mmu_pkg::ROWCOL_W-1:0]        i_row,
    input  logic [mmu_pkg::ROWCOL_W-1:0]        i_col,
    input  logic signed [mmu_pkg::VALUE_W-1:0]  i_value,
    output logic                                o_full,
    output mmu_pkg::t_cmd_status                o_cmd,
    output logic [ADDR_W-1:0]                   o_cmd_addr,
    output logic [DATA_WIDTH-1:0]               o_cmd_value,
    input  logic                                i_cmd_pop
);

    logic                  keep, in_range, cmd_empty;
    logic [ADDR_W-1:0]     addr;
    logic [DATA_WIDTH-1:0] value_st;
    logic [CMD_W-1:0]      cmd_in, cmd_out;
    mmu_pkg::t_op          op_q;

    assign in_range = (32'(i_row) < MAX_DIM) && (32'(i_col) < MAX_DIM);

    always_comb begin
        unique case (i_op) inside
            mmu_pkg::OP_WRITE_A, mmu_pkg::OP_WRITE_B: keep = in_range;
            mmu_pkg::OP_COMPUTE:                      keep = 1'b1;
            default:                                  keep = 1'b0;
        endcase
    end

    // row-major element address; narrow stores keep the low bits
    assign addr     = ADDR_W'(int'(i_row) * MAX_DIM + int'(i_col));
    assign value_st = DATA_WIDTH'(i_value);
    assign cmd_in   = {i_op, addr, value_st};

    mmu_fifo #(
        .WIDTH (CMD_W),
        .DEPTH (mmu_pkg::CMD_DEPTH)
    ) u_cmd_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (i_push && keep),
        .i_data  (cmd_in),
        .i_pop   (i_cmd_pop),
        .o_data  (cmd_out),
        .o_full  (o_full),
        .o_empty (cmd_empty),
        .o_count ()
    );

    assign {op_q, o_cmd_addr, o_cmd_value} = cmd_out;
    assign o_cmd = '{avail: !cmd_empty, op: op_q};

endmodule

>>> sv/mmu_back.sv
// Back end: operand stores, MAC sequencer and result queue.
`include "matrix_multiply_unit_defines.svh"
module mmu_back #(
    parameter int MAX_DIM    = mmu_pkg::MAX_DIM_DEF,
    parameter int DATA_WIDTH = mmu_pkg::DATA_WIDTH_DEF,
    localparam int ADDR_W = $clog2(MAX_DIM * MAX_DIM),
    localparam int IDX_W  = $clog2(MAX_DIM),
    localparam int DIM_W  = $clog2(MAX_DIM + 1)
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  mmu_pkg::t_cmd_status                  i_cmd,
    input  logic [ADDR_W-1:0]                     i_cmd_addr,
    input  logic [DATA_WIDTH-1:0]                 i_cmd_value,
    output logic                                  o_cmd_pop,
    input  logic [mmu_pkg::CFG_W-1:0]             i_rows_a,
    input  logic [mmu_pkg::CFG_W-1:0]             i_inner_dim,
    input  logic [mmu_pkg::CFG_W-1:0]             i_cols_b,
    input  logic                                  i_res_pop,
    output logic                                  o_res_empty,
    output logic signed [mmu_pkg::PRODUCT_W-1:0]  o_product,
    output logic [mmu_pkg::ROWCOL_W-1:0]          o_out_row,
    output logic [mmu_pkg::ROWCOL_W-1:0]          o_out_col,
    output logic                                  o_last
);

    localparam int PW        = mmu_pkg::PRODUCT_W;
    localparam int RES_W     = PW + 2 * mmu_pkg::ROWCOL_W + 1;
    localparam int RES_CNT_W = $clog2(mmu_pkg::RES_DEPTH + 1);

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_RUN  = 2'b10
    } t_state;

    t_state                 r_state, n_state;
    logic [IDX_W-1:0]       r_i, r_j, r_r;
    logic [IDX_W-1:0]       r_nlast, r_llast, r_rlast;
    logic                   r_kzero;
    logic [DIM_W-1:0]       n_c, k_c, l_c;
    logic                   start, issue, credit_ok, step_last, entry_last;
    logic                   we_a, we_b;
    logic [ADDR_W-1:0]      a_raddr, b_raddr;
    logic [DATA_WIDTH-1:0]  a_rdata, b_rdata;
    logic signed [2*DATA_WIDTH-1:0] mul;
    mmu_pkg::t_step_tag     step_tag;
    logic                   r_s1_valid, r_s2_valid;
    mmu_pkg::t_step_tag     r_s1_tag, r_s2_tag;
    logic signed [PW-1:0]   r_prod, r_acc, n_acc;
    logic                   res_push, res_full;
    logic [RES_W-1:0]       res_in, res_out;
    logic [RES_CNT_W-1:0]   res_count, r_inflight;

    function automatic logic [DIM_W-1:0] clamp_dim(input logic [mmu_pkg::CFG_W-1:0] d);
        logic [DIM_W-1:0] res;
        if (32'(d) > MAX_DIM) res = DIM_W'(MAX_DIM);
        else res = DIM_W'(d);
        return res;
    endfunction

    assign n_c = clamp_dim(i_rows_a);
    assign k_c = clamp_dim(i_inner_dim);
    assign l_c = clamp_dim(i_cols_b);

    // command dispatch
    assign o_cmd_pop = (r_state == S_IDLE) && i_cmd.avail;

    always_comb begin
        we_a  = 1'b0;
        we_b  = 1'b0;
        start = 1'b0;
        if (o_cmd_pop) begin
            unique case (i_cmd.op)
                mmu_pkg::OP_WRITE_A: we_a = 1'b1;
                mmu_pkg::OP_WRITE_B: we_b = 1'b1;
                mmu_pkg::OP_COMPUTE: start = (n_c != '0) && (l_c != '0);
                default:             start = 1'b0;
            endcase
        end
    end

    // an entry starts only with a result slot reserved for it
    assign credit_ok  = (r_r != '0) ||
                        ((int'(res_count) + int'(r_inflight)) < mmu_pkg::RES_DEPTH);
    assign issue      = (r_state == S_RUN) && credit_ok;
    assign step_last  = (r_r == r_rlast);
    assign entry_last = step_last && (r_j == r_llast) && (r_i == r_nlast);

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:  if (start) n_state = S_RUN;
            S_RUN:   if (issue && entry_last) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (start) begin
            r_i     <= '0;
            r_j     <= '0;
            r_r     <= '0;
            r_nlast <= IDX_W'(n_c - DIM_W'(1));
            r_llast <= IDX_W'(l_c - DIM_W'(1));
            r_kzero <= (k_c == '0);
            r_rlast <= (k_c == '0) ? '0 : IDX_W'(k_c - DIM_W'(1));
        end else if (issue) begin
            if (step_last) begin
                r_r <= '0;
                if (r_j == r_llast) begin
                    r_j <= '0;
                    r_i <= r_i + 1'b1;
                end else begin
                    r_j <= r_j + 1'b1;
                end
            end else begin
                r_r <= r_r + 1'b1;
            end
        end
    end

    assign a_raddr = ADDR_W'(int'(r_i) * MAX_DIM + int'(r_r));
    assign b_raddr = ADDR_W'(int'(r_r) * MAX_DIM + int'(r_j));

    mmu_ram #(
        .WIDTH (DATA_WIDTH),
        .DEPTH (MAX_DIM * MAX_DIM)
    ) u_store_a (
        .i_clk   (i_clk),
        .i_we    (we_a),
        .i_waddr (i_cmd_addr),
        .i_wdata (i_cmd_value),
        .i_raddr (a_raddr),
        .o_rdata (a_rdata)
    );

    mmu_ram #(
        .WIDTH (DATA_WIDTH),
        .DEPTH (MAX_DIM * MAX_DIM)
    ) u_store_b (
        .i_clk   (i_clk),
        .i_we    (we_b),
        .i_waddr (i_cmd_addr),
        .i_wdata (i_cmd_value),
        .i_raddr (b_raddr),
        .o_rdata (b_rdata)
    );

    // MAC pipeline: read, multiply, accumulate
    assign step_tag = '{first: (r_r == '0), last: step_last, zero: r_kzero,
                        fin: entry_last,
                        row: mmu_pkg::ROWCOL_W'(r_i), col: mmu_pkg::ROWCOL_W'(r_j)};
    assign mul = $signed(a_rdata) * $signed(b_rdata);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_s2_valid <= 1'b0;
        end else begin
            r_s1_valid <= issue;
            r_s2_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s1_tag <= step_tag;
        r_s2_tag <= r_s1_tag;
        r_prod   <= r_s1_tag.zero ? '0 : PW'(mul);
        if (r_s2_valid) r_acc <= n_acc;
    end

    assign n_acc    = (r_s2_tag.first ? '0 : r_acc) + r_prod;
    assign res_push = r_s2_valid && r_s2_tag.last;
    assign res_in   = {n_acc, r_s2_tag.row, r_s2_tag.col, r_s2_tag.fin};

    // entries fully issued but not yet in the result queue
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_inflight <= '0;
        end else begin
            case ({issue && step_last, res_push})
                2'b10:   r_inflight <= r_inflight + 1'b1;
                2'b01:   r_inflight <= r_inflight - 1'b1;
                default: r_inflight <= r_inflight;
            endcase
        end
    end

    mmu_fifo #(
        .WIDTH (RES_W),
        .DEPTH (mmu_pkg::RES_DEPTH)
    ) u_res_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (res_push),
        .i_data  (res_in),
        .i_pop   (i_res_pop),
        .o_data  (res_out),
        .o_full  (res_full),
        .o_empty (o_res_empty),
        .o_count (res_count)
    );

    assign {o_product, o_out_row, o_out_col, o_last} = res_out;

    `MMU_ASSERT_IMPLY(a_res_no_overflow, i_clk, i_rst_n, res_push, !res_full)
    `MMU_ASSERT_IMPLY(a_credit_bound, i_clk, i_rst_n, 1'b1, (int'(res_count) + int'(r_inflight)) <= mmu_pkg::RES_DEPTH)
    `MMU_ASSERT_NEXT(a_run_ends, i_clk, i_rst_n, issue && entry_last, r_state == S_IDLE)

endmodule
